// File: rtl/core/gbts_pkg.sv
package gbts_pkg;

    // Marks written into the store
    localparam logic [7:0] GAP_MARK  = 8'd95;  // '_'
    localparam logic [7:0] FILL_MARK = 8'd45;  // '-'
    localparam logic [7:0] OOR_CHAR  = 8'd48;  // '0'

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [7:0] position;
        logic [7:0] char_in;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_char;
        logic [7:0] gap_start_out;
        logic [7:0] gap_end_out;
    } res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOVE,
        ST_COPY,
        ST_MARK,
        ST_READ,
        ST_FINISH
    } state_t;

endpackage

// File: rtl/core/gbts_ram.sv
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // hold the last read word when no read is issued
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/core/gap_buffer_text_store.sv
// Gap buffer text store: one result word per command word, one command at a time.
// Flow: a read goes through ST_READ, an insert at the current gap through ST_MOVE, and an
// insert past the text straight to ST_FINISH, which loads the result word once the output
// register is free. Each character the gap moves takes a read, a copy write and a mark write.
// Reset: a clearing pass fills the store with '-'; cmd_stall stays high until it is done.
// Gap pointers and handshake state reset at once.
module gap_buffer_text_store #(
    parameter int CAPACITY = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  gbts_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_stall,
    output gbts_pkg::res_t res
);

    import gbts_pkg::*;

    // Address width of the store and a compare width that holds both
    // CAPACITY itself and any 8-bit position.
    localparam int AW = $clog2(CAPACITY);
    localparam int WW = ((AW > 8) ? AW : 8) + 1;

    localparam logic [WW-1:0] CAP_W   = WW'(CAPACITY);
    localparam logic [WW-1:0] LAST_W  = WW'(CAPACITY - 1);
    localparam logic [AW-1:0] LAST_A  = AW'(CAPACITY - 1);
    localparam logic [AW-1:0] ONE_A   = AW'(1);

    state_t          state_reg, state_next;
    logic [AW-1:0]   gs_reg, gs_next;       // first gap slot
    logic [AW-1:0]   ge_reg, ge_next;       // last gap slot, inclusive
    logic [AW-1:0]   clr_reg, clr_next;     // clearing pass address
    logic            out_valid_reg, out_valid_next;

    // Per-command working registers (payload, no reset)
    logic [AW-1:0]   target_reg, target_next;
    logic [7:0]      ch_reg, ch_next;
    logic            left_reg, left_next;   // gap moves toward slot 0
    logic [AW-1:0]   mark_reg, mark_next;   // slot vacated by the last copy
    logic [1:0]      status_reg, status_next;
    logic [7:0]      rd_reg, rd_next;
    res_t            out_reg, out_next;

    // Store port signals
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [7:0]      wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;

    logic [WW-1:0]   pos_w;
    logic [WW-1:0]   len_w;

    gbts_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Text length: slots before the gap plus slots after it.
    assign pos_w = WW'(cmd.position);
    assign len_w = WW'(gs_reg) + (LAST_W - WW'(ge_reg));

    // Take a new command only when the previous one has left the working
    // registers; a finished result may still wait in the output register.
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        gs_next        = gs_reg;
        ge_next        = ge_reg;
        clr_next       = clr_reg;
        target_next    = target_reg;
        ch_next        = ch_reg;
        left_next      = left_reg;
        mark_next      = mark_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        out_next       = out_reg;
        // drop the result word once the consumer takes it
        out_valid_next = out_valid_reg && res_stall;

        wr_en   = 1'b0;
        wr_addr = gs_reg;
        wr_data = ch_reg;
        rd_en   = 1'b0;
        rd_addr = gs_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // fill one slot per cycle with the reset mark
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = FILL_MARK;
                clr_next = clr_reg + ONE_A;
                if (clr_reg == LAST_A)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    target_next = AW'(pos_w);
                    ch_next     = cmd.char_in;
                    if (cmd.operation == OP_READ)
                    begin
                        if (pos_w < CAP_W)
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = AW'(pos_w);
                            status_next = STAT_OK;
                            state_next  = ST_READ;
                        end
                        else
                        begin
                            status_next = STAT_RANGE;
                            rd_next     = OOR_CHAR;
                            state_next  = ST_FINISH;
                        end
                    end
                    else
                    begin
                        rd_next = 8'd0;
                        if (pos_w > len_w)
                        begin
                            status_next = STAT_RANGE;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            status_next = STAT_OK;
                            state_next  = ST_MOVE;
                        end
                    end
                end
            end

            ST_MOVE:
            begin
                if ((target_reg < gs_reg) && (gs_reg != '0))
                begin
                    // fetch the character just before the gap
                    rd_en      = 1'b1;
                    rd_addr    = gs_reg - ONE_A;
                    left_next  = 1'b1;
                    state_next = ST_COPY;
                end
                else if ((target_reg > gs_reg) && ((WW'(ge_reg) + WW'(1)) < CAP_W))
                begin
                    // fetch the character just after the gap
                    rd_en      = 1'b1;
                    rd_addr    = ge_reg + ONE_A;
                    left_next  = 1'b0;
                    state_next = ST_COPY;
                end
                else if (gs_reg == ge_reg)
                begin
                    // one gap slot left: keep it, report full
                    status_next = STAT_FULL;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = gs_reg;
                    wr_data    = ch_reg;
                    gs_next    = gs_reg + ONE_A;
                    state_next = ST_FINISH;
                end
            end

            ST_COPY:
            begin
                // copy the fetched character across the gap and shift the gap
                wr_en   = 1'b1;
                wr_data = rd_data;
                if (left_reg)
                begin
                    wr_addr   = ge_reg;
                    gs_next   = gs_reg - ONE_A;
                    ge_next   = ge_reg - ONE_A;
                    mark_next = gs_reg - ONE_A;
                end
                else
                begin
                    wr_addr   = gs_reg;
                    gs_next   = gs_reg + ONE_A;
                    ge_next   = ge_reg + ONE_A;
                    mark_next = ge_reg + ONE_A;
                end
                state_next = ST_MARK;
            end

            ST_MARK:
            begin
                wr_en      = 1'b1;
                wr_addr    = mark_reg;
                wr_data    = GAP_MARK;
                state_next = ST_MOVE;
            end

            ST_READ:
            begin
                rd_next    = rd_data;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // load the result word once the output register is free
                if (!out_valid_reg || !res_stall)
                begin
                    out_next.status        = status_reg;
                    out_next.read_char     = rd_reg;
                    out_next.gap_start_out = 8'(gs_reg);
                    out_next.gap_end_out   = 8'(ge_reg);
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            gs_reg        <= '0;
            ge_reg        <= LAST_A;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gs_reg        <= gs_next;
            ge_reg        <= ge_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        ch_reg     <= ch_next;
        left_reg   <= left_next;
        mark_reg   <= mark_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        out_reg    <= out_next;
    end

endmodule
